/* hw/rtl/ilbp_pkg.sv */
package ilbp_pkg;

  localparam logic [7:0] MAX_VERSION = 8'd2;
  localparam logic [3:0] SZ_FOUR     = 4'd4;
  localparam logic [3:0] SZ_EIGHT    = 4'd8;
  localparam logic [3:0] LEN_FLAGS   = 4'd3;
  localparam logic [3:0] LEN_BYTE    = 4'd1;
  localparam logic [3:0] LEN_SHORT   = 4'd2;
  localparam logic [3:0] LEN_LONG    = 4'd4;

  typedef enum logic [13:0] {
    PH_IDLE   = 14'b00000000000001,
    PH_FLAGS  = 14'b00000000000010,
    PH_SIZE_A = 14'b00000000000100,
    PH_SIZE_B = 14'b00000000001000,
    PH_COUNT  = 14'b00000000010000,
    PH_ID     = 14'b00000000100000,
    PH_METHOD = 14'b00000001000000,
    PH_DREF   = 14'b00000010000000,
    PH_BASE   = 14'b00000100000000,
    PH_EXTCNT = 14'b00001000000000,
    PH_INDEX  = 14'b00010000000000,
    PH_OFFSET = 14'b00100000000000,
    PH_LENGTH = 14'b01000000000000,
    PH_DRAIN  = 14'b10000000000000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_VERSION  = 2'd1,
    ST_ZERO_ITEMS   = 2'd2,
    ST_ZERO_EXTENTS = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       box_start;
  } beat_t;

  typedef struct packed {
    logic [31:0] item_ident;
    logic [3:0]  build_method;
    logic [15:0] data_ref;
    logic [63:0] item_base;
    logic [63:0] extent_idx;
    logic [63:0] extent_start;
    logic [63:0] extent_len;
    logic        item_done;
    logic        box_done;
    status_t     status;
  } rec_t;

  // Field byte count from a size nibble: 4 or 8, anything else reads nothing.
  function automatic logic [3:0] size_bytes(input logic [3:0] nib);
    logic [3:0] n;
    n = 4'd0;
    if (nib == SZ_FOUR) n = SZ_FOUR;
    if (nib == SZ_EIGHT) n = SZ_EIGHT;
    return n;
  endfunction

endpackage

/* hw/rtl/ilbp_in_if.sv */
interface ilbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       box_start;

  modport source (output valid, output payload_byte, output box_start, input ready);
  modport sink   (input valid, input payload_byte, input box_start, output ready);
endinterface

/* hw/rtl/ilbp_out_if.sv */
interface ilbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] item_ident;
  logic [3:0]  build_method;
  logic [15:0] data_ref;
  logic [63:0] item_base;
  logic [63:0] extent_idx;
  logic [63:0] extent_start;
  logic [63:0] extent_len;
  logic        item_done;
  logic        box_done;
  logic [1:0]  status;

  modport source (
    output valid, output item_ident, output build_method, output data_ref,
    output item_base, output extent_idx, output extent_start, output extent_len,
    output item_done, output box_done, output status, input ready
  );
  modport sink (
    input valid, input item_ident, input build_method, input data_ref,
    input item_base, input extent_idx, input extent_start, input extent_len,
    input item_done, input box_done, input status, output ready
  );
endinterface

/* hw/rtl/item_location_box_parser_unit.sv */
// Item location box parser. Takes the box payload one byte per beat on
// "payload", starting at the version byte flagged by box_start, and gives one
// record per extent on "extents" (item, method, data reference, base offset,
// extent index/offset/length, last-of-item and last-of-box marks). A bad
// version, zero item count or zero extent count gives a single error record
// (box_done set, status nonzero, other fields 0) and the parser then ignores
// bytes until the next box_start; box_start always restarts it. Rate: one
// byte per cycle while the extents output is not stalled, since the parse
// step for a byte is combinational ahead of the phase state register. The
// byte that completes an extent passes the input register, then the result
// register, to its record. With index, offset and length sizes all zero,
// each further extent of an item takes one extra beat whose byte is dropped.
module item_location_box_parser_unit
  import ilbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ilbp_in_if.sink    payload,
  ilbp_out_if.source extents
);

  // input stage
  logic  in_valid;
  beat_t in_beat;
  logic  adv;
  logic  in_ready;

  logic  present;
  rec_t  rec_new;
  rec_t  rec;

  assign in_ready      = !in_valid || adv;
  assign payload.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= payload.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && payload.valid) begin
      in_beat.payload_byte <= payload.payload_byte;
      in_beat.box_start    <= payload.box_start;
    end
  end

  // parse step runs when a beat is held and the result slot can take output
  ilbp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (in_valid && adv),
    .beat    (in_beat),
    .present (present),
    .rec     (rec_new)
  );

  ilbp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .take   (extents.ready),
    .load   (in_valid && present),
    .rec_in (rec_new),
    .free   (adv),
    .valid  (extents.valid),
    .rec    (rec)
  );

  assign extents.item_ident   = rec.item_ident;
  assign extents.build_method = rec.build_method;
  assign extents.data_ref     = rec.data_ref;
  assign extents.item_base    = rec.item_base;
  assign extents.extent_idx   = rec.extent_idx;
  assign extents.extent_start = rec.extent_start;
  assign extents.extent_len   = rec.extent_len;
  assign extents.item_done    = rec.item_done;
  assign extents.box_done     = rec.box_done;
  assign extents.status       = rec.status;

endmodule

/* hw/rtl/ilbp_parse.sv */
module ilbp_parse
  import ilbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  beat_t beat,
  output logic  present,
  output rec_t  rec
);

  phase_t      phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [1:0]  version, version_next;
  logic [15:0] sizes, sizes_next;
  logic [31:0] items_left, items_left_next;
  logic [15:0] extents_left, extents_left_next;
  logic [31:0] cur_item, cur_item_next;
  logic [3:0]  cur_method, cur_method_next;
  logic [15:0] cur_dref, cur_dref_next;
  logic [63:0] cur_base, cur_base_next;
  logic [63:0] cur_index, cur_index_next;
  logic [63:0] cur_offset, cur_offset_next;
  logic [63:0] accum, accum_next;

  logic [63:0] accum_new;
  logic [3:0]  pos_inc;
  logic [3:0]  cur_len, short_long, base_len, idx_len, off_len, ln_len;
  logic        ext_zero;
  phase_t      ext_first;
  logic        emit, err;
  status_t     err_code;
  logic [63:0] emit_len;
  logic [15:0] ext_dec;
  logic [31:0] items_dec;
  logic        idone, bdone;

  // sizes: [15:12] offset, [11:8] length, [7:4] base, [3:0] index
  assign short_long = (version < 2'd2) ? LEN_SHORT : LEN_LONG;
  assign base_len   = size_bytes(sizes[7:4]);
  assign idx_len    = (version != 2'd0) ? size_bytes(sizes[3:0]) : 4'd0;
  assign off_len    = size_bytes(sizes[15:12]);
  assign ln_len     = size_bytes(sizes[11:8]);
  assign ext_zero   = (idx_len == 4'd0) && (off_len == 4'd0) && (ln_len == 4'd0);
  assign ext_first  = (idx_len != 4'd0) ? PH_INDEX :
                      (off_len != 4'd0) ? PH_OFFSET : PH_LENGTH;

  assign accum_new = {((byte_pos == 4'd0) ? 56'd0 : accum[55:0]), beat.payload_byte};
  assign pos_inc   = byte_pos + 4'd1;

  always_comb begin
    unique case (phase)
      PH_FLAGS:                        cur_len = LEN_FLAGS;
      PH_SIZE_A, PH_SIZE_B:            cur_len = LEN_BYTE;
      PH_COUNT, PH_ID:                 cur_len = short_long;
      PH_METHOD, PH_DREF, PH_EXTCNT:   cur_len = LEN_SHORT;
      PH_BASE:                         cur_len = base_len;
      PH_INDEX:                        cur_len = idx_len;
      PH_OFFSET:                       cur_len = off_len;
      PH_LENGTH:                       cur_len = ln_len;
      default:                         cur_len = 4'd0;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    version_next      = version;
    sizes_next        = sizes;
    items_left_next   = items_left;
    extents_left_next = extents_left;
    cur_item_next     = cur_item;
    cur_method_next   = cur_method;
    cur_dref_next     = cur_dref;
    cur_base_next     = cur_base;
    cur_index_next    = cur_index;
    cur_offset_next   = cur_offset;
    accum_next        = accum;
    emit      = 1'b0;
    emit_len  = 64'd0;
    err       = 1'b0;
    err_code  = ST_OK;
    present   = 1'b0;
    rec       = '0;
    ext_dec   = 16'd0;
    items_dec = 32'd0;
    idone     = 1'b0;
    bdone     = 1'b0;

    if (step) begin
      if (beat.box_start) begin
        byte_pos_next = 4'd0;
        if (beat.payload_byte > MAX_VERSION) begin
          err          = 1'b1;
          err_code     = ST_BAD_VERSION;
          version_next = 2'd0;
        end else begin
          version_next = beat.payload_byte[1:0];
          phase_next   = PH_FLAGS;
        end
      end else if (phase == PH_DRAIN) begin
        // empty extent: one beat per record, byte dropped
        emit = 1'b1;
      end else if (phase != PH_IDLE) begin
        byte_pos_next = pos_inc;
        accum_next    = accum_new;
        if (pos_inc == cur_len) begin
          byte_pos_next = 4'd0;
          unique case (phase)
            PH_FLAGS:  phase_next = PH_SIZE_A;
            PH_SIZE_A: begin
              sizes_next[15:8] = accum_new[7:0];
              phase_next       = PH_SIZE_B;
            end
            PH_SIZE_B: begin
              sizes_next[7:0] = accum_new[7:0];
              phase_next      = PH_COUNT;
            end
            PH_COUNT: begin
              items_left_next = accum_new[31:0];
              if (accum_new[31:0] == 32'd0) begin
                err      = 1'b1;
                err_code = ST_ZERO_ITEMS;
              end else begin
                phase_next = PH_ID;
              end
            end
            PH_ID: begin
              cur_item_next   = accum_new[31:0];
              cur_method_next = 4'd0;
              phase_next      = (version != 2'd0) ? PH_METHOD : PH_DREF;
            end
            PH_METHOD: begin
              cur_method_next = accum_new[3:0];
              phase_next      = PH_DREF;
            end
            PH_DREF: begin
              cur_dref_next = accum_new[15:0];
              cur_base_next = 64'd0;
              phase_next    = (base_len != 4'd0) ? PH_BASE : PH_EXTCNT;
            end
            PH_BASE: begin
              cur_base_next = accum_new;
              phase_next    = PH_EXTCNT;
            end
            PH_EXTCNT: begin
              extents_left_next = accum_new[15:0];
              cur_index_next    = 64'd0;
              cur_offset_next   = 64'd0;
              if (accum_new[15:0] == 16'd0) begin
                err      = 1'b1;
                err_code = ST_ZERO_EXTENTS;
              end else if (ext_zero) begin
                emit = 1'b1;
              end else begin
                phase_next = ext_first;
              end
            end
            PH_INDEX: begin
              cur_index_next = accum_new;
              if (off_len != 4'd0) phase_next = PH_OFFSET;
              else if (ln_len != 4'd0) phase_next = PH_LENGTH;
              else emit = 1'b1;
            end
            PH_OFFSET: begin
              cur_offset_next = accum_new;
              if (ln_len != 4'd0) phase_next = PH_LENGTH;
              else emit = 1'b1;
            end
            PH_LENGTH: begin
              emit     = 1'b1;
              emit_len = accum_new;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end

      if (err) begin
        present       = 1'b1;
        rec.box_done  = 1'b1;
        rec.status    = err_code;
        phase_next    = PH_IDLE;
        byte_pos_next = 4'd0;
      end else if (emit) begin
        ext_dec   = extents_left_next - 16'd1;
        idone     = (ext_dec == 16'd0);
        items_dec = items_left_next - {31'd0, idone};
        bdone     = idone && (items_dec == 32'd0);

        present          = 1'b1;
        rec.item_ident   = cur_item_next;
        rec.build_method = cur_method_next;
        rec.data_ref     = cur_dref_next;
        rec.item_base    = cur_base_next;
        rec.extent_idx   = cur_index_next;
        rec.extent_start = cur_offset_next;
        rec.extent_len   = emit_len;
        rec.item_done    = idone;
        rec.box_done     = bdone;
        rec.status       = ST_OK;

        extents_left_next = ext_dec;
        items_left_next   = items_dec;
        byte_pos_next     = 4'd0;
        if (!idone) begin
          cur_index_next  = 64'd0;
          cur_offset_next = 64'd0;
          phase_next      = ext_zero ? PH_DRAIN : ext_first;
        end else if (!bdone) begin
          phase_next = PH_ID;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      byte_pos <= 4'd0;
      version  <= 2'd0;
    end else begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      version  <= version_next;
    end
  end

  always_ff @(posedge clk) begin
    sizes        <= sizes_next;
    items_left   <= items_left_next;
    extents_left <= extents_left_next;
    cur_item     <= cur_item_next;
    cur_method   <= cur_method_next;
    cur_dref     <= cur_dref_next;
    cur_base     <= cur_base_next;
    cur_index    <= cur_index_next;
    cur_offset   <= cur_offset_next;
    accum        <= accum_next;
  end

endmodule

/* hw/rtl/ilbp_out_reg.sv */
module ilbp_out_reg
  import ilbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  logic load,
  input  rec_t rec_in,
  output logic free,
  output logic valid,
  output rec_t rec
);

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      rec <= rec_in;
    end
  end

endmodule
